// File: rtl/vibrato_delay_line_top_assert.svh
// Assertion macros for the vibrato delay line checker.
// Both macros expect signals named clk and rst_n in the using scope.
`ifndef VIBRATO_DELAY_LINE_TOP_ASSERT_SVH
`define VIBRATO_DELAY_LINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VDL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define VDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vdl_pkg.sv
// Shared types and constants for the vibrato delay line.
// No dependencies; imported by every other file of the block except the assertion header.
`timescale 1ns / 1ps

package vdl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int INT_W      = 8;   // integer bits of the 8.24 read position
  localparam int SWAY_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [FRAC_W-1:0]          frac_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [SWAY_W-1:0]          sway_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWAY_SHIFT = 2'd0,
    CFG_DRY_MIX    = 2'd1,
    CFG_PHASE_STEP = 2'd2
  } cfg_reg_t;

  localparam sway_t  SWAY_RST = 5'd2;
  localparam logic   DRY_RST  = 1'b0;
  localparam phase_t STEP_RST = 32'd679632;

  // Side data that travels with an item alongside the two delay taps.
  typedef struct packed {
    frac_t   frac;
    sample_t dry;
  } tap_t;

endpackage

// File: rtl/vdl_if.sv
// Stream interfaces for the input and result channels.
// Depends on vdl_pkg for the sample type.
`timescale 1ns / 1ps

interface vdl_in_if import vdl_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface vdl_out_if import vdl_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/vdl_addr.sv
// LFO phase, write pointer and read address generation.
// Depends on vdl_pkg.
`timescale 1ns / 1ps

module vdl_addr import vdl_pkg::*; #(
  parameter int  DELAY_LEN = 128,
  localparam int IDX_W     = $clog2(DELAY_LEN)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  sway_t            sway_shift,
  input  phase_t           phase_step,
  output logic [IDX_W-1:0] wr_idx,
  output logic [IDX_W-1:0] rd_idx_a,
  output logic [IDX_W-1:0] rd_idx_b,
  output frac_t            frac
);

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  phase_t           phase_r, phase_nxt;
  phase_t           wave, wave_sh, rd_pos;
  logic [INT_W-1:0] pos_int;
  logic [IDX_W-1:0] wrap_tbl [2**INT_W];

  // Signed integer position (-128..127) reduced modulo the line length.
  for (genvar g = 0; g < 2**INT_W; g++) begin : g_wrap
    localparam int SPOS = (g >= 2**(INT_W-1)) ? g - 2**INT_W : g;
    localparam int WPOS = ((SPOS % DELAY_LEN) + DELAY_LEN) % DELAY_LEN;
    assign wrap_tbl[g] = IDX_W'(WPOS);
  end

  always_comb begin
    wave     = phase_r[PHASE_W-1] ? (~phase_r + 1'b1) : phase_r;
    wave_sh  = wave >> sway_shift;
    rd_pos   = {INT_W'(wr_idx_r), {(PHASE_W-INT_W){1'b0}}} - wave_sh;
    pos_int  = rd_pos[PHASE_W-1 -: INT_W];
    frac     = rd_pos[PHASE_W-INT_W-1 -: FRAC_W];
    rd_idx_a = wrap_tbl[pos_int];
    rd_idx_b = (rd_idx_a == IDX_W'(DELAY_LEN-1)) ? '0 : rd_idx_a + 1'b1;
    wr_idx   = wr_idx_r;
  end

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    phase_nxt  = phase_r;
    if (adv) begin
      wr_idx_nxt = (wr_idx_r == IDX_W'(DELAY_LEN-1)) ? '0 : wr_idx_r + 1'b1;
      phase_nxt  = phase_r + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      phase_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

// File: rtl/vdl_mem.sv
// Delay line storage: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero. Depends on vdl_pkg.
`timescale 1ns / 1ps

module vdl_mem import vdl_pkg::*; #(
  parameter int  DELAY_LEN = 128,
  localparam int IDX_W     = $clog2(DELAY_LEN)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  sample_t          wr_data,
  input  logic [IDX_W-1:0] rd_idx_a,
  input  logic [IDX_W-1:0] rd_idx_b,
  output sample_t          rd_a,
  output sample_t          rd_b
);

  sample_t              mem_r [DELAY_LEN];
  logic [DELAY_LEN-1:0] valid_r;
  sample_t              rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Reads happen with the write of the same item; the current slot bypasses.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      priority if (rd_idx_a == wr_idx) begin
        rd_a_r <= wr_data;
      end else if (!valid_r[rd_idx_a]) begin
        rd_a_r <= '0;
      end else begin
        rd_a_r <= mem_r[rd_idx_a];
      end
      priority if (rd_idx_b == wr_idx) begin
        rd_b_r <= wr_data;
      end else if (!valid_r[rd_idx_b]) begin
        rd_b_r <= '0;
      end else begin
        rd_b_r <= mem_r[rd_idx_b];
      end
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// File: rtl/vdl_interp.sv
// Linear interpolation, dry mix and the result register.
// Depends on vdl_pkg.
`timescale 1ns / 1ps

module vdl_interp import vdl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  sample_t tap_a,
  input  sample_t tap_b,
  input  tap_t    tap,
  input  logic    dry_mix,
  output logic    take,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t sample_out
);

  localparam int PROD_W = FRAC_W + SAMPLE_W + 2;
  localparam int ACC_W  = FRAC_W + SAMPLE_W + 4;

  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  sample_t                   a2_r, x2_r;
  logic                      out_valid_r;
  sample_t                   out_data_r, out_data_nxt;
  logic                      out_move;
  logic signed [SAMPLE_W:0]  diff;
  logic signed [FRAC_W:0]    frac_s;
  logic signed [ACC_W-1:0]   a_ext, acc;
  logic signed [SAMPLE_W:0]  wet_ext, mix_sum;

  assign out_move = !out_valid_r || out_ready;
  assign take     = !s2_v_r || out_move;

  // (0xFFFF - f)*a + f*b rewritten as a*0xFFFF + f*(b - a): one multiplier.
  always_comb begin
    diff     = (SAMPLE_W+1)'(tap_b) - (SAMPLE_W+1)'(tap_a);
    frac_s   = $signed({1'b0, tap.frac});
    prod_nxt = PROD_W'(frac_s) * PROD_W'(diff);
  end

  always_comb begin
    a_ext        = ACC_W'(a2_r);
    acc          = (a_ext <<< FRAC_W) - a_ext + ACC_W'(prod_r);
    wet_ext      = (SAMPLE_W+1)'(acc[FRAC_W +: SAMPLE_W]);
    mix_sum      = (SAMPLE_W+1)'($signed(acc[FRAC_W +: SAMPLE_W])) + (SAMPLE_W+1)'(x2_r);
    out_data_nxt = dry_mix ? mix_sum[SAMPLE_W:1] : wet_ext[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        s2_v_r <= in_valid;
      end
      if (out_move) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      prod_r <= prod_nxt;
      a2_r   <= tap_a;
      x2_r   <= tap.dry;
    end
    if (out_move && s2_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = out_data_r;

endmodule

// File: rtl/vibrato_delay_line_top.sv
// Vibrato delay line: top level with configuration registers and pipeline control.
// Depends on vdl_pkg, vdl_if, vdl_addr, vdl_mem and vdl_interp.
`timescale 1ns / 1ps

// Vibrato delay line. Each input item is one signed 16-bit sample; each
// produces exactly one 16-bit result item, in order. The sample is written
// into a DELAY_LEN-entry delay line and read back at a position swept by a
// triangle LFO (32-bit phase, advanced by phase_step per item, depth set by
// sway_shift), linearly interpolated between two neighbouring taps and,
// with dry_mix set, averaged with the input sample. Throughput is one item
// per clock while the result side does not stall; each item has its taps
// read at the accepting edge, then is multiplied, then summed and mixed
// into the result register. The delay line reads as zero after reset
// through per-entry valid bits, so there is no clearing pass. Registers
// are written through cfg_we/cfg_idx/cfg_data: 0 sway_shift, 1 dry_mix,
// 2 phase_step; index 3 is ignored. Write them only while the block is
// idle.
module vibrato_delay_line_top import vdl_pkg::*; #(
  parameter int DELAY_LEN = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vdl_in_if.sink                in_if,
  vdl_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(DELAY_LEN);

  // Configuration registers
  sway_t  sway_r;
  logic   dry_r;
  phase_t step_r;

  // Stage 1: taps in flight from the memory, plus their side data
  logic   s1_v_r;
  tap_t   s1_tap_r;

  logic             accept;
  logic             take;
  logic             in_ready;
  logic [IDX_W-1:0] wr_idx, rd_idx_a, rd_idx_b;
  frac_t            frac;
  sample_t          tap_a, tap_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sway_r <= SWAY_RST;
      dry_r  <= DRY_RST;
      step_r <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SWAY_SHIFT: sway_r <= cfg_data[SWAY_W-1:0];
        CFG_DRY_MIX:    dry_r  <= cfg_data[0];
        CFG_PHASE_STEP: step_r <= cfg_data[PHASE_W-1:0];
        default: ;      // no register at this index
      endcase
    end
  end

  // Stage 1 is free when empty or when its item moves on this cycle.
  assign in_ready    = !s1_v_r || take;
  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tap_r <= '{frac: frac, dry: in_if.sample_in};
    end
  end

  // LFO and pointers advance once per accepted item.
  vdl_addr #(
    .DELAY_LEN (DELAY_LEN)
  ) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (accept),
    .sway_shift (sway_r),
    .phase_step (step_r),
    .wr_idx     (wr_idx),
    .rd_idx_a   (rd_idx_a),
    .rd_idx_b   (rd_idx_b),
    .frac       (frac)
  );

  // Write and both tap reads happen at the accepting edge.
  vdl_mem #(
    .DELAY_LEN (DELAY_LEN)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_idx   (wr_idx),
    .wr_data  (in_if.sample_in),
    .rd_idx_a (rd_idx_a),
    .rd_idx_b (rd_idx_b),
    .rd_a     (tap_a),
    .rd_b     (tap_b)
  );

  vdl_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_v_r),
    .tap_a      (tap_a),
    .tap_b      (tap_b),
    .tap        (s1_tap_r),
    .dry_mix    (dry_r),
    .take       (take),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .sample_out (out_if.sample_out)
  );

endmodule

// File: rtl/vdl_checker.sv
// Port-level checks for the vibrato delay line, bound to the top level.
// Depends on vdl_pkg and vibrato_delay_line_top_assert.svh.
`timescale 1ns / 1ps
`include "vibrato_delay_line_top_assert.svh"

module vdl_checker import vdl_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_sample
);

  // A stalled result holds its value.
  `VDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample), "vdl: stalled result changed")

  // With the result side free the whole pipeline moves, so input is taken.
  `VDL_ASSERT_IMPL(a_ready_free, !out_valid || out_ready, in_ready, "vdl: input blocked while result side free")

  // Nothing is presented in the cycle after reset.
  `VDL_ASSERT_IMPL(a_empty_after_rst, !$past(rst_n), !out_valid, "vdl: result valid straight after reset")

  // An input held back is only held while a result waits.
  `VDL_ASSERT_IMPL(a_stall_cause, in_valid && !in_ready, out_valid && !out_ready, "vdl: input stalled without a waiting result")

endmodule

bind vibrato_delay_line_top vdl_checker u_vdl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_sample (out_if.sample_out)
);

// File: tb/vdl_checker.sv
// Scoreboard for the vibrato delay line: tracks register writes, predicts each result.
// Depends on vdl_pkg and on the vdl_in_if / vdl_out_if stream interfaces.
`timescale 1ns / 1ps

module vdl_scoreboard import vdl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vdl_in_if                     in_ch,
  vdl_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int LINE_LEN = 128;

  // Shadow copy of the block's state and registers
  sample_t    delay_mem [LINE_LEN];
  logic [6:0] wr_ptr;
  phase_t     lfo_acc;
  sway_t      depth_shift;
  logic       mix_on;
  phase_t     lfo_step;

  sample_t    vibrato_q [$];
  int         mismatches  = 0;
  int         outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
    $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Writes the sample, interpolates between the two taps at the swept position, optionally mixes dry, then advances
  function automatic sample_t vibrato_sample(input sample_t x);
    phase_t     tri_val;
    phase_t     rd_pos;
    logic [6:0] tap_a;
    logic [6:0] tap_b;
    longint     frac;
    longint     acc;
    longint     mixed;
    delay_mem[wr_ptr] = x;
    // triangle peaks at 0x80000000; upper half folds back as 2^32 - p
    tri_val = lfo_acc[PHASE_W-1] ? (32'h0 - lfo_acc) : lfo_acc;
    rd_pos  = {1'b0, wr_ptr, 24'h0} - (tri_val >> depth_shift);
    // integer part modulo 128, so negative positions wrap
    tap_a   = rd_pos[30:24];
    tap_b   = rd_pos[30:24] + 7'd1;
    frac    = longint'(rd_pos[23:8]);
    acc     = (65535 - frac) * longint'(delay_mem[tap_a]) + frac * longint'(delay_mem[tap_b]);
    mixed   = acc >>> 16;
    if (mix_on)
      mixed = (mixed + longint'(x)) >>> 1;
    lfo_acc = lfo_acc + lfo_step;
    wr_ptr  = wr_ptr + 7'd1;
    return sample_t'(mixed[15:0]);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      for (int k = 0; k < LINE_LEN; k++)
        delay_mem[k] = '0;
      wr_ptr      = '0;
      lfo_acc     = '0;
      depth_shift = SWAY_RST;
      mix_on      = DRY_RST;
      lfo_step    = STEP_RST;
      vibrato_q.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SWAY_SHIFT: depth_shift = cfg_data[SWAY_W-1:0];
          CFG_DRY_MIX:    mix_on      = cfg_data[0];
          CFG_PHASE_STEP: lfo_step    = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (vibrato_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_ch.sample_out, '0);
        end else begin
          want = vibrato_q.pop_front();
          if (out_ch.sample_out !== want)
            report_mismatch("sample_out differs", out_ch.sample_out, want);
        end
      end
      if (in_ch.valid && in_ch.ready)
        vibrato_q.push_back(vibrato_sample(in_ch.sample_in));
    end
    outstanding <= vibrato_q.size();
  end

endmodule

// File: tb/tb_vibrato_delay_line_top.sv
// Top of the vibrato delay line testbench: clock, reset, stimulus and verdict.
// Depends on vdl_pkg, vdl_if, vibrato_delay_line_top and vdl_scoreboard.
`timescale 1ns / 1ps

module tb_vibrato_delay_line_top;
  import vdl_pkg::*;

  localparam int RUN_LIMIT  = 400000;  // cycles before the watchdog ends the run
  localparam int PIPE_DRAIN = 8;       // extra cycles waited after the last result
  // index 3 has no register behind it; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Locally held drives, so every input is known from time zero
  logic                  in_valid  = 1'b0;
  sample_t               in_sample = '0;
  logic                  res_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Idle percentages for each side; changed between phases of the run
  int send_idle_pct = 26;
  int res_idle_pct  = 45;
  int cycle_count   = 0;
  int fail_count;
  int pending;

  vdl_in_if  in_ch ();
  vdl_out_if out_ch ();

  assign in_ch.valid     = in_valid;
  assign in_ch.sample_in = in_sample;
  assign out_ch.ready    = res_ready;

  vibrato_delay_line_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  vdl_scoreboard u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= res_idle_pct);
  end

  // Watchdog: a hung handshake or lost result ends up here
  initial begin
    while (cycle_count < RUN_LIMIT)
      @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // One item: optional random gap with valid low, then hold valid until taken.
  // valid is only lowered on the gap path, so back-to-back items keep it high.
  task automatic send_sample(input sample_t s);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and let every outstanding result come back, plus a short drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // All three registers, then optionally the spare index, in one burst; cfg_we stays high across it
  task automatic program_regs(input sway_t sw, input logic mix, input phase_t step,
                              input bit poke_spare);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SWAY_SHIFT;
    cfg_data <= CFG_DATA_W'(sw);
    @(posedge clk);
    cfg_idx  <= CFG_DRY_MIX;
    cfg_data <= CFG_DATA_W'(mix);
    @(posedge clk);
    cfg_idx  <= CFG_PHASE_STEP;
    cfg_data <= step;
    @(posedge clk);
    if (poke_spare) begin
      cfg_idx  <= CFG_SPARE_IDX;
      cfg_data <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly full-range noise, with the rails and near-zero thrown in
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return sample_t'($urandom_range(0, 3)) - 16'sd2;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Depth, rate and dry mix settings for a random segment; extremes turn up often
  task automatic random_regs();
    sway_t  sw;
    phase_t step;
    case ($urandom_range(0, 3))
      0:       sw = '0;
      1:       sw = '1;
      2:       sw = sway_t'($urandom_range(0, 8));
      default: sw = sway_t'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = '1;
      2:       step = 32'h8000_0000;
      3:       step = $urandom;
      default: step = $urandom_range(1, 32'h0040_0000);
    endcase
    program_regs(sw, 1'($urandom), step, ($urandom_range(0, 7) == 0));
  endtask

  // Sends n_items items (630 per idling phase below), in segments with fresh settings between
  task automatic random_phase(input int n_items);
    int sent;
    int seg_len;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      random_regs();
      seg_len = $urandom_range(60, 150);
      for (int k = 0; k < seg_len && sent < n_items; k++) begin
        send_sample(pick_sample());
        sent++;
      end
    end
  endtask

  initial begin
    sample_t edge_vals [7];
    edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, 16'shaaaa};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, the rails and alternating bit patterns
    foreach (edge_vals[k])
      send_sample(edge_vals[k]);

    // Zero shift with a half-turn step: on alternate items nearly the full 0x80000000
    // peak is subtracted, the read index goes negative and wraps; dry mix averages with the input
    wait_idle();
    program_regs('0, 1'b1, 32'h8000_0000, 1'b0);
    foreach (edge_vals[k])
      send_sample(edge_vals[k]);

    // Deepest shift: the read lands on the slot just written (current sample),
    // and the spare index gets a write that must change nothing
    wait_idle();
    program_regs('1, 1'b0, 32'hffff_ffff, 1'b1);
    foreach (edge_vals[k])
      send_sample(edge_vals[k]);

    // Random part, three idling regimes
    random_phase(630);
    send_idle_pct = 45;
    res_idle_pct  = 26;
    random_phase(630);
    send_idle_pct = 0;
    res_idle_pct  = 0;
    random_phase(630);

    // Drain, let any stray result surface, then judge away from the edge
    wait_idle();
    @(negedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
